/* hw/rtl/five_axis_ac_point_transform_unit_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the A-over-C point transform
// Shared concurrent checks, clocked and disabled by reset.
// ----------------------------------------------------------------------------
`ifndef FIVE_AXIS_AC_POINT_TRANSFORM_UNIT_MACROS_SVH
`define FIVE_AXIS_AC_POINT_TRANSFORM_UNIT_MACROS_SVH

// Same-cycle implication
`define FATAC_ASSERT_IMPLIES(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error("fatac check failed: same-cycle implication");

// Next-cycle implication
`define FATAC_ASSERT_NEXT(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error("fatac check failed: next-cycle implication");

`endif

/* hw/rtl/fatac_pkg.sv */
// ----------------------------------------------------------------------------
// fatac_pkg
// Widths, register indexes, types and the clamp function of the transform.
// ----------------------------------------------------------------------------
package fatac_pkg;

   localparam int COORD_WIDTH    = 32;
   localparam int TRIG_FRAC_BITS = 16;
   localparam int TRIG_WIDTH     = TRIG_FRAC_BITS + 2;
   localparam int CSR_DATA_WIDTH = 32;
   localparam int CSR_INDEX_WIDTH = 4;

   // point minus center, exact
   localparam int DIFF_WIDTH  = COORD_WIDTH + 1;
   // trig value widened so that its negation always fits
   localparam int TRIGX_WIDTH = TRIG_WIDTH + 1;
   localparam int PROD_WIDTH  = DIFF_WIDTH + TRIGX_WIDTH;
   localparam int SUM_WIDTH   = PROD_WIDTH + 1;
   localparam int RND_WIDTH   = SUM_WIDTH - TRIG_FRAC_BITS;
   localparam int TOT_WIDTH   = RND_WIDTH + 1;

   localparam logic signed [SUM_WIDTH-1:0] ROUND_HALF =
      SUM_WIDTH'(1) << (TRIG_FRAC_BITS - 1);

   localparam logic signed [TRIG_WIDTH-1:0] TRIG_ONE = TRIG_WIDTH'(1) << TRIG_FRAC_BITS;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_CHILD_CENTER_X   = 4'd0,
      CSR_CHILD_CENTER_Y   = 4'd1,
      CSR_PRIMARY_CENTER_Y = 4'd2,
      CSR_PRIMARY_CENTER_Z = 4'd3,
      CSR_C_COSINE         = 4'd4,
      CSR_C_SINE           = 4'd5,
      CSR_A_COSINE         = 4'd6,
      CSR_A_SINE           = 4'd7
   } csr_index_type;

   // center and trig values of one planar rotation
   typedef struct packed {
      logic signed [COORD_WIDTH-1:0] center_u;
      logic signed [COORD_WIDTH-1:0] center_v;
      logic signed [TRIG_WIDTH-1:0]  cosine;
      logic signed [TRIG_WIDTH-1:0]  sine;
   } rot_cfg_type;

   typedef struct packed {
      logic signed [COORD_WIDTH-1:0] value;
      logic                          clamped;
   } clamp_type;

   // clamp a wide sum to the signed coordinate range
   function automatic clamp_type clamp_coord(input logic signed [TOT_WIDTH-1:0] v);
      clamp_type r;
      r.clamped = 1'b0;
      r.value   = v[COORD_WIDTH-1:0];
      if (!v[TOT_WIDTH-1] && (|v[TOT_WIDTH-2:COORD_WIDTH-1])) begin
         r.clamped = 1'b1;
         r.value   = {1'b0, {(COORD_WIDTH-1){1'b1}}};
      end else if (v[TOT_WIDTH-1] && !(&v[TOT_WIDTH-2:COORD_WIDTH-1])) begin
         r.clamped = 1'b1;
         r.value   = {1'b1, {(COORD_WIDTH-1){1'b0}}};
      end
      return r;
   endfunction

endpackage

/* hw/rtl/fatac_csr.sv */
// ----------------------------------------------------------------------------
// fatac_csr
// Configuration registers; sorts them into the C and A rotation groups.
// ----------------------------------------------------------------------------
module fatac_csr
   import fatac_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_we,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_wdata,
   output rot_cfg_type                c_cfg,
   output rot_cfg_type                a_cfg
);

   rot_cfg_type c_cfg_ff, c_cfg_in;
   rot_cfg_type a_cfg_ff, a_cfg_in;

   // decode the write; drop unknown indexes
   always_comb begin
      c_cfg_in = c_cfg_ff;
      a_cfg_in = a_cfg_ff;
      if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_CHILD_CENTER_X:   c_cfg_in.center_u = csr_wdata[COORD_WIDTH-1:0];
            CSR_CHILD_CENTER_Y:   c_cfg_in.center_v = csr_wdata[COORD_WIDTH-1:0];
            CSR_PRIMARY_CENTER_Y: a_cfg_in.center_u = csr_wdata[COORD_WIDTH-1:0];
            CSR_PRIMARY_CENTER_Z: a_cfg_in.center_v = csr_wdata[COORD_WIDTH-1:0];
            CSR_C_COSINE:         c_cfg_in.cosine   = csr_wdata[TRIG_WIDTH-1:0];
            CSR_C_SINE:           c_cfg_in.sine     = csr_wdata[TRIG_WIDTH-1:0];
            CSR_A_COSINE:         a_cfg_in.cosine   = csr_wdata[TRIG_WIDTH-1:0];
            CSR_A_SINE:           a_cfg_in.sine     = csr_wdata[TRIG_WIDTH-1:0];
            default: begin
            end
         endcase
      end
   end

   // hold the registers; reset to identity rotation about the origin
   always_ff @(posedge clock) begin
      if (reset) begin
         c_cfg_ff <= '{center_u: '0, center_v: '0, cosine: TRIG_ONE, sine: '0};
         a_cfg_ff <= '{center_u: '0, center_v: '0, cosine: TRIG_ONE, sine: '0};
      end else begin
         c_cfg_ff <= c_cfg_in;
         a_cfg_ff <= a_cfg_in;
      end
   end

   assign c_cfg = c_cfg_ff;
   assign a_cfg = a_cfg_ff;

endmodule

/* hw/rtl/fatac_rot.sv */
// ----------------------------------------------------------------------------
// fatac_rot
// Three-stage planar rotation about a center: difference, multiply,
// round + add center + clamp. A third coordinate rides along unchanged.
// ----------------------------------------------------------------------------
`include "five_axis_ac_point_transform_unit_macros.svh"

module fatac_rot
   import fatac_pkg::*;
(
   input  logic                          clock,
   input  logic                          reset,
   input  rot_cfg_type                   cfg,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  logic signed [COORD_WIDTH-1:0] in_u,
   input  logic signed [COORD_WIDTH-1:0] in_v,
   input  logic signed [COORD_WIDTH-1:0] in_w,
   input  logic                          in_sat,
   output logic                          out_valid,
   input  logic                          out_ready,
   output logic signed [COORD_WIDTH-1:0] out_u,
   output logic signed [COORD_WIDTH-1:0] out_v,
   output logic signed [COORD_WIDTH-1:0] out_w,
   output logic                          out_sat
);

   logic ready1, ready2, ready3;

   logic v1_ff, v1_in, v2_ff, v2_in, v3_ff, v3_in;

   logic signed [DIFF_WIDTH-1:0]  du_ff, du_in, dv_ff, dv_in;
   logic signed [COORD_WIDTH-1:0] w1_ff, w1_in, w2_ff, w2_in, w3_ff, w3_in;
   logic                          s1_ff, s1_in, s2_ff, s2_in, s3_ff, s3_in;

   logic signed [PROD_WIDTH-1:0]  puc_ff, puc_in, pvs_ff, pvs_in;
   logic signed [PROD_WIDTH-1:0]  pus_ff, pus_in, pvc_ff, pvc_in;

   logic signed [COORD_WIDTH-1:0] u3_ff, u3_in, v3d_ff, v3d_in;

   logic signed [TRIGX_WIDTH-1:0] cos_x, sin_x, neg_sin_x;
   logic signed [SUM_WIDTH-1:0]   sum_u, sum_v;
   logic signed [RND_WIDTH-1:0]   rnd_u, rnd_v;
   logic signed [TOT_WIDTH-1:0]   tot_u, tot_v;
   clamp_type                     clp_u, clp_v;

   // a stage takes a new word when it is empty or its word moves on
   assign ready3   = !v3_ff || out_ready;
   assign ready2   = !v2_ff || ready3;
   assign ready1   = !v1_ff || ready2;
   assign in_ready = ready1;

   // stage 1: offsets from the center
   always_comb begin
      v1_in = ready1 ? in_valid : v1_ff;
      du_in = DIFF_WIDTH'(in_u) - DIFF_WIDTH'(cfg.center_u);
      dv_in = DIFF_WIDTH'(in_v) - DIFF_WIDTH'(cfg.center_v);
      w1_in = in_w;
      s1_in = in_sat;
   end

   // stage 2: the four products
   always_comb begin
      cos_x     = TRIGX_WIDTH'(cfg.cosine);
      sin_x     = TRIGX_WIDTH'(cfg.sine);
      neg_sin_x = -sin_x;
      v2_in     = ready2 ? v1_ff : v2_ff;
      puc_in    = du_ff * cos_x;
      pvs_in    = dv_ff * neg_sin_x;
      pus_in    = du_ff * sin_x;
      pvc_in    = dv_ff * cos_x;
      w2_in     = w1_ff;
      s2_in     = s1_ff;
   end

   // stage 3: sum pairs, round half up, add center, clamp
   always_comb begin
      sum_u  = SUM_WIDTH'(puc_ff) + SUM_WIDTH'(pvs_ff) + ROUND_HALF;
      sum_v  = SUM_WIDTH'(pus_ff) + SUM_WIDTH'(pvc_ff) + ROUND_HALF;
      rnd_u  = sum_u[SUM_WIDTH-1:TRIG_FRAC_BITS];
      rnd_v  = sum_v[SUM_WIDTH-1:TRIG_FRAC_BITS];
      tot_u  = TOT_WIDTH'(rnd_u) + TOT_WIDTH'(cfg.center_u);
      tot_v  = TOT_WIDTH'(rnd_v) + TOT_WIDTH'(cfg.center_v);
      clp_u  = clamp_coord(tot_u);
      clp_v  = clamp_coord(tot_v);
      v3_in  = ready3 ? v2_ff : v3_ff;
      u3_in  = clp_u.value;
      v3d_in = clp_v.value;
      w3_in  = w2_ff;
      s3_in  = s2_ff || clp_u.clamped || clp_v.clamped;
   end

   // advance valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
      end
   end

   // advance payload; hold while stalled
   always_ff @(posedge clock) begin
      if (ready1) begin
         du_ff <= du_in;
         dv_ff <= dv_in;
         w1_ff <= w1_in;
         s1_ff <= s1_in;
      end
      if (ready2) begin
         puc_ff <= puc_in;
         pvs_ff <= pvs_in;
         pus_ff <= pus_in;
         pvc_ff <= pvc_in;
         w2_ff  <= w2_in;
         s2_ff  <= s2_in;
      end
      if (ready3) begin
         u3_ff  <= u3_in;
         v3d_ff <= v3d_in;
         w3_ff  <= w3_in;
         s3_ff  <= s3_in;
      end
   end

   assign out_valid = v3_ff;
   assign out_u     = u3_ff;
   assign out_v     = v3d_ff;
   assign out_w     = w3_ff;
   assign out_sat   = s3_ff;

   // checks
   `FATAC_ASSERT_IMPLIES(a_full_when_blocked, clock, reset, !in_ready, v1_ff && v2_ff && v3_ff)
   `FATAC_ASSERT_NEXT(a_accept_lands, clock, reset, in_valid && in_ready, v1_ff)
   `FATAC_ASSERT_NEXT(a_stall_keeps_mid, clock, reset, v2_ff && !ready3, v2_ff)
   `FATAC_ASSERT_NEXT(a_sat_carried, clock, reset, v2_ff && ready3 && s2_ff, out_sat)

endmodule

/* hw/rtl/five_axis_ac_point_transform_unit.sv */
// Throughput: one point per cycle while rsp_ready is high; six register stages (two
//   rotation units of difference, multiply and round/clamp) each hold one word and keep it on a stall.
// Reset: synchronous, active high; empties the pipeline and sets centers to 0,
//   cosines to 1.0 and sines to 0.
// ----------------------------------------------------------------------------
// five_axis_ac_point_transform_unit
// A-over-C table kinematics: rotate about C around the child center, then
// about A around the primary center; saturate with a sticky flag.
// ----------------------------------------------------------------------------
module five_axis_ac_point_transform_unit
   import fatac_pkg::*;
(
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_we,
   input  logic [CSR_INDEX_WIDTH-1:0]    csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]     csr_wdata,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic signed [COORD_WIDTH-1:0] req_x_in,
   input  logic signed [COORD_WIDTH-1:0] req_y_in,
   input  logic signed [COORD_WIDTH-1:0] req_z_in,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic signed [COORD_WIDTH-1:0] rsp_x_out,
   output logic signed [COORD_WIDTH-1:0] rsp_y_out,
   output logic signed [COORD_WIDTH-1:0] rsp_z_out,
   output logic                          rsp_saturated
);

   rot_cfg_type c_cfg, a_cfg;

   logic                          mid_valid, mid_ready, mid_sat;
   logic signed [COORD_WIDTH-1:0] mid_x, mid_y, mid_z;

   // configuration registers
   fatac_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .c_cfg     (c_cfg),
      .a_cfg     (a_cfg)
   );

   // C rotation in the XY plane, Z rides along
   fatac_rot u_rot_c (
      .clock     (clock),
      .reset     (reset),
      .cfg       (c_cfg),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_u      (req_x_in),
      .in_v      (req_y_in),
      .in_w      (req_z_in),
      .in_sat    (1'b0),
      .out_valid (mid_valid),
      .out_ready (mid_ready),
      .out_u     (mid_x),
      .out_v     (mid_y),
      .out_w     (mid_z),
      .out_sat   (mid_sat)
   );

   // A rotation in the YZ plane, X rides along
   fatac_rot u_rot_a (
      .clock     (clock),
      .reset     (reset),
      .cfg       (a_cfg),
      .in_valid  (mid_valid),
      .in_ready  (mid_ready),
      .in_u      (mid_y),
      .in_v      (mid_z),
      .in_w      (mid_x),
      .in_sat    (mid_sat),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_u     (rsp_y_out),
      .out_v     (rsp_z_out),
      .out_w     (rsp_x_out),
      .out_sat   (rsp_saturated)
   );

endmodule
